FILE: hdl/hcbp_pkg.sv
// Package for the Huffman code bit packer.
// Item kinds, field widths and table entry layout; no dependencies.
`default_nettype none

package hcbp_pkg;

  // Field widths of the channels
  localparam int unsigned KindW   = 2;
  localparam int unsigned SymW    = 8;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned LenW    = 6;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TotalW  = 32;

  // Longest code word kept in the table; longer loads are clipped
  localparam int unsigned MaxCodeLen = 32;
  localparam int unsigned LenCap     = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;

  // Pending byte plus the longest code word, as a merge window
  localparam int unsigned WinW  = ByteW + CodeW;
  // Result bytes one symbol can complete, and the counter for them
  localparam int unsigned MaxRes = WinW / ByteW - 1;
  localparam int unsigned ResW   = 3;

  // Table entry: code word above its length
  localparam int unsigned EntryW = CodeW + LenW;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

endpackage

`default_nettype wire

FILE: hdl/hcbp_if.sv
// Channel interfaces of the Huffman code bit packer: input items and results.
// Depends on hcbp_pkg for field widths.
`default_nettype none

interface hcbp_in_if;
  import hcbp_pkg::*;
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [SymW-1:0]     symbol;
  logic [CodeW-1:0]    code_word;
  logic [LenW-1:0]     code_length;

  modport source (output valid, kind, symbol, code_word, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;
  logic                valid;
  logic                ready;
  logic [ByteW-1:0]    out_byte;
  logic                byte_present;
  logic [TotalW-1:0]   total_bits;
  logic                unknown_symbol;
  logic                last;

  modport source (output valid, out_byte, byte_present, total_bits, unknown_symbol, last,
                  input ready);
  modport sink   (input valid, out_byte, byte_present, total_bits, unknown_symbol, last,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/huffman_code_bit_packer_top.sv
// Huffman encoder with a symbol-indexed code table and an MSB-first byte packer.
// Depends on hcbp_pkg and the channel interfaces in hcbp_if.sv.
//
//   channel | dir | carries
//   --------+-----+------------------------------------------------
//   in_i    | in  | kind, symbol, code_word, code_length
//   out_o   | out | out_byte, byte_present, total_bits, unknown_symbol, last
//
// An item is taken every cycle while the packer stage does not stall: the table
// memory is read at the input transfer and the packer merges in the next cycle.
// Result bytes leave one per cycle from the result buffer while the output is
// ready; a packer step with results waits for the buffer, one without does not.
// Reset clears the loaded flags, packer, bit count and handshake state; the
// table memory itself is not cleared. A stalled output holds the packer stage.
`default_nettype none

module huffman_code_bit_packer_top
  import hcbp_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  hcbp_in_if.sink     in_i,
  hcbp_out_if.source  out_o
);

  localparam int unsigned IdxW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // Table memory and loaded flags
  logic [EntryW-1:0]       mem_q [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] loaded_q;
  logic [EntryW-1:0]       rd_q;

  // Packer stage
  logic                    s1_valid_q;
  logic [KindW-1:0]        s1_kind_q;
  logic                    s1_hit_q;
  logic [ByteW-1:0]        pend_byte_q, pend_byte_d;
  logic [2:0]              pend_fill_q, pend_fill_d;
  logic [TotalW-1:0]       bit_total_q, bit_total_d;

  // Result buffer
  logic [ResW-1:0]         rem_q;
  logic [MaxRes*ByteW-1:0] obuf_q;
  logic [TotalW-1:0]       ototal_q;
  logic                    opresent_q;
  logic                    ounknown_q;

  logic                    in_xfer;
  logic                    out_xfer;
  logic [IdxW-1:0]         idx;
  logic                    sym_in_range;
  logic [LenW-1:0]         len_capped;

  logic                    s1_go;
  logic                    obuf_free;
  logic [ResW-1:0]         res_cnt;
  logic [MaxRes*ByteW-1:0] res_buf;
  logic [TotalW-1:0]       res_total;
  logic                    res_present;
  logic                    res_unknown;

  logic [CodeW-1:0]        s1_word;
  logic [LenW-1:0]         s1_len;
  logic [LenW-1:0]         fill_sum;
  logic [LenW-1:0]         shamt;
  logic [CodeW:0]          mask;
  logic [WinW-1:0]         win;
  logic [TotalW:0]         total_sum;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;

  assign idx          = in_i.symbol[IdxW-1:0];
  assign sym_in_range = {1'b0, in_i.symbol} < (SymW + 1)'(SYMBOL_COUNT);
  assign len_capped   = (in_i.code_length > LenW'(LenCap)) ? LenW'(LenCap) : in_i.code_length;

  // Table write on load, registered read on encode
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_i.kind == KIND_LOAD && sym_in_range) begin
      mem_q[idx] <= {in_i.code_word, len_capped};
    end
    if (in_xfer && in_i.kind == KIND_ENCODE) begin
      rd_q <= mem_q[idx];
    end
  end

  // Loaded flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else if (in_xfer && in_i.kind == KIND_LOAD && sym_in_range) begin
      loaded_q[idx] <= 1'b1;
    end
  end

  // Packer stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid &&
                    (in_i.kind == KIND_ENCODE || in_i.kind == KIND_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q <= in_i.kind;
      s1_hit_q  <= sym_in_range && loaded_q[idx];
    end
  end

  // Merge the code word into the pending byte
  assign s1_word   = rd_q[EntryW-1:LenW];
  assign s1_len    = rd_q[LenW-1:0];
  assign fill_sum  = LenW'(pend_fill_q) + s1_len;
  assign shamt     = LenW'(WinW) - fill_sum;
  assign mask      = ((CodeW + 1)'(1) << s1_len) - (CodeW + 1)'(1);
  assign win       = {pend_byte_q, CodeW'(0)}
                   | ({ByteW'(0), s1_word & mask[CodeW-1:0]} << shamt);
  assign total_sum = {1'b0, bit_total_q} + (TotalW + 1)'(s1_len);

  // Results and next packer state per kind
  always_comb begin
    res_cnt     = '0;
    res_buf     = win[WinW-1:ByteW];
    res_total   = bit_total_q;
    res_present = 1'b1;
    res_unknown = 1'b0;
    pend_byte_d = pend_byte_q;
    pend_fill_d = pend_fill_q;
    bit_total_d = bit_total_q;
    case (s1_kind_q)
      KIND_ENCODE: begin
        if (s1_hit_q) begin
          res_cnt     = fill_sum[LenW-1:3];
          bit_total_d = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
          res_total   = bit_total_d;
          pend_fill_d = fill_sum[2:0];
          case (fill_sum[LenW-1:3])
            3'd0:    pend_byte_d = win[39:32];
            3'd1:    pend_byte_d = win[31:24];
            3'd2:    pend_byte_d = win[23:16];
            3'd3:    pend_byte_d = win[15:8];
            default: pend_byte_d = win[7:0];
          endcase
        end else begin
          res_cnt     = ResW'(1);
          res_buf     = '0;
          res_present = 1'b0;
          res_unknown = 1'b1;
        end
      end
      KIND_FINISH: begin
        res_cnt     = ResW'(1);
        res_present = (pend_fill_q != '0);
        res_buf     = {(res_present ? pend_byte_q : ByteW'(0)), {(MaxRes-1)*ByteW{1'b0}}};
        pend_byte_d = '0;
        pend_fill_d = '0;
        bit_total_d = '0;
      end
      default: begin
        res_cnt = '0;
      end
    endcase
  end

  assign obuf_free  = (rem_q == '0) || (rem_q == ResW'(1) && out_o.ready);
  assign s1_go      = s1_valid_q && (res_cnt == '0 || obuf_free);
  assign in_i.ready = !s1_valid_q || s1_go;

  // Packer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_byte_q <= '0;
      pend_fill_q <= '0;
      bit_total_q <= '0;
    end else if (s1_go) begin
      pend_byte_q <= pend_byte_d;
      pend_fill_q <= pend_fill_d;
      bit_total_q <= bit_total_d;
    end
  end

  // Result buffer: load on a packer step with results, shift out per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (s1_go && res_cnt != '0) begin
      rem_q <= res_cnt;
    end else if (out_xfer) begin
      rem_q <= rem_q - ResW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res_cnt != '0) begin
      obuf_q     <= res_buf;
      ototal_q   <= res_total;
      opresent_q <= res_present;
      ounknown_q <= res_unknown;
    end else if (out_xfer) begin
      obuf_q <= obuf_q << ByteW;
    end
  end

  assign out_o.valid          = (rem_q != '0);
  assign out_o.out_byte       = obuf_q[MaxRes*ByteW-1 -: ByteW];
  assign out_o.byte_present   = opresent_q;
  assign out_o.total_bits     = ototal_q;
  assign out_o.unknown_symbol = ounknown_q;
  assign out_o.last           = (rem_q == ResW'(1));

endmodule

`default_nettype wire

FILE: tb/sv/huffman_code_bit_packer_top_tb.sv
// Testbench for the Huffman code bit packer: table loads, symbol encodes, flushes.
// Depends on hcbp_pkg, the channel interfaces in hcbp_if.sv and huffman_code_bit_packer_top.
`default_nettype none

module huffman_code_bit_packer_top_tb;
  import hcbp_pkg::*;

  localparam int unsigned SymbolCount = 256;
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned RandomItems = 380;
  localparam int unsigned MaxBytesPerSym = 4;
  localparam int unsigned IdlePct = 25;

  // One result transfer as the packer should emit it
  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              byte_present;
    logic [TotalW-1:0] total_bits;
    logic              unknown_symbol;
    logic              last;
  } packed_out_t;

  // Code table mirror, packer state and the bytes still owed by the block
  class bitstream_checker;
    logic [CodeW-1:0]  code_mem [SymbolCount];
    logic [LenW-1:0]   len_mem  [SymbolCount];
    bit                loaded   [SymbolCount];
    logic [ByteW-1:0]  acc_byte;
    int unsigned       acc_fill;
    logic [TotalW-1:0] bit_count;
    packed_out_t       owed_bytes [$];
    int unsigned       errors;
    int unsigned       items_seen;
    int unsigned       results_seen;
    int unsigned       unknown_seen;
    int unsigned       flushes_seen;

    function new();
      foreach (loaded[i]) loaded[i] = 1'b0;
      acc_byte = '0;
      acc_fill = 0;
      bit_count = '0;
      errors = 0;
      items_seen = 0;
      results_seen = 0;
      unknown_seen = 0;
      flushes_seen = 0;
    endfunction

    // One line per mismatch; printing is capped, counting is not
    task report(string what);
      errors++;
      if (errors <= 60) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_field(string name, logic [TotalW-1:0] got, logic [TotalW-1:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Predict what one accepted input transfer produces
    task take_item(logic [KindW-1:0] kind, logic [SymW-1:0] sym,
                   logic [CodeW-1:0] word, logic [LenW-1:0] len);
      logic [ByteW-1:0] done_bytes [MaxBytesPerSym];
      int unsigned      n_done;
      int unsigned      eff_len;
      logic [TotalW:0]  sum;
      packed_out_t      r;
      items_seen++;
      n_done = 0;
      case (kind)
        KIND_LOAD: begin
          if (sym < SymbolCount) begin
            code_mem[sym] = word;
            len_mem[sym]  = (len > LenCap) ? LenW'(LenCap) : len;
            loaded[sym]   = 1'b1;
          end
        end
        KIND_ENCODE: begin
          if (sym >= SymbolCount || !loaded[sym]) begin
            r = '{out_byte: '0, byte_present: 1'b0, total_bits: bit_count,
                  unknown_symbol: 1'b1, last: 1'b1};
            owed_bytes.push_back(r);
          end else begin
            eff_len = (len_mem[sym] > CodeW) ? CodeW : len_mem[sym];
            // shift code bits in, first bit into the top of the byte
            for (int i = eff_len; i > 0; i--) begin
              acc_byte[7 - acc_fill] = code_mem[sym][i-1];
              acc_fill++;
              if (acc_fill == 8) begin
                if (n_done < MaxBytesPerSym) done_bytes[n_done] = acc_byte;
                n_done++;
                acc_byte = '0;
                acc_fill = 0;
              end
            end
            sum = {1'b0, bit_count} + eff_len;
            bit_count = sum[TotalW] ? '1 : sum[TotalW-1:0];
            if (n_done > MaxBytesPerSym) n_done = MaxBytesPerSym;
            for (int i = 0; i < n_done; i++) begin
              r = '{out_byte: done_bytes[i], byte_present: 1'b1, total_bits: bit_count,
                    unknown_symbol: 1'b0, last: (i + 1 == n_done)};
              owed_bytes.push_back(r);
            end
          end
        end
        KIND_FINISH: begin
          r = '{out_byte: (acc_fill > 0) ? acc_byte : '0, byte_present: (acc_fill > 0),
                total_bits: bit_count, unknown_symbol: 1'b0, last: 1'b1};
          owed_bytes.push_back(r);
          acc_byte = '0;
          acc_fill = 0;
          bit_count = '0;
        end
        default: ;
      endcase
    endtask

    // Compare one result transfer against the oldest owed one
    task match_result(packed_out_t got);
      packed_out_t want;
      results_seen++;
      if (got.unknown_symbol) unknown_seen++;
      if (owed_bytes.size() == 0) begin
        report($sformatf("unexpected result 0x%0h", got));
        return;
      end
      want = owed_bytes.pop_front();
      if (want.unknown_symbol == 1'b0 && want.last && !want.byte_present) flushes_seen++;
      check_field("out_byte", got.out_byte, want.out_byte);
      check_field("byte_present", got.byte_present, want.byte_present);
      check_field("total_bits", got.total_bits, want.total_bits);
      check_field("unknown_symbol", got.unknown_symbol, want.unknown_symbol);
      check_field("last", got.last, want.last);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer_top #(
    .SYMBOL_COUNT(SymbolCount)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  bitstream_checker book;
  logic [SymW-1:0]  known_syms [$];

  // Clock, period 8
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Drive one input item and wait for its transfer
  task automatic push_item(logic [KindW-1:0] kind, logic [SymW-1:0] sym,
                           logic [CodeW-1:0] word, logic [LenW-1:0] len);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.symbol      <= sym;
    in_ch.code_word   <= word;
    in_ch.code_length <= len;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    book.take_item(kind, sym, word, len);
    if (kind == KIND_LOAD) known_syms.push_back(sym);
  endtask

  // Result sink with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      book.match_result('{out_byte: out_ch.out_byte, byte_present: out_ch.byte_present,
                          total_bits: out_ch.total_bits, unknown_symbol: out_ch.unknown_symbol,
                          last: out_ch.last});
    end
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // Stimulus and end of run
  initial begin
    int unsigned      n_sent;
    int unsigned      pick;
    logic [SymW-1:0]  sym;
    logic [LenW-1:0]  len;
    book = new();
    steady = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.symbol = '0;
    in_ch.code_word = '0;
    in_ch.code_length = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty flush, unknown symbol, unused kind, overlong lengths
    push_item(KIND_FINISH, 8'h00, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'h5A, 32'hFFFF_FFFF, 6'h3F);
    push_item(KindUnused, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    push_item(KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    push_item(KIND_LOAD, 8'hFF, 32'h0000_0000, 6'd0);
    push_item(KIND_LOAD, 8'h01, 32'h0000_0005, 6'd3);
    push_item(KIND_LOAD, 8'h02, 32'hABCD_1234, 6'd63);
    push_item(KIND_LOAD, 8'h03, 32'h8000_0001, 6'd33);
    push_item(KIND_ENCODE, 8'h00, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'hFF, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'h03, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0);
    push_item(KIND_FINISH, 8'h00, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'h00, 32'h0, 6'd0);
    push_item(KIND_FINISH, 8'h00, 32'h0, 6'd0);
    push_item(KIND_LOAD, 8'h01, 32'h0000_007F, 6'd7);
    push_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
    push_item(KIND_ENCODE, 8'h5A, 32'h0, 6'd0);
    push_item(KIND_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);

    // Random: mostly encodes of loaded symbols, with loads, flushes and noise
    n_sent = 0;
    while (n_sent < RandomItems) begin
      steady = (n_sent >= 150 && n_sent < 250);
      pick = $urandom_range(0, 99);
      if (pick < 20 || known_syms.size() == 0) begin
        sym = SymW'($urandom_range(0, SymbolCount - 1));
        pick = $urandom_range(0, 99);
        if (pick < 5) len = '0;
        else if (pick < 60) len = LenW'($urandom_range(1, 12));
        else if (pick < 88) len = LenW'($urandom_range(13, 32));
        else len = LenW'($urandom_range(33, 63));
        push_item(KIND_LOAD, sym, $urandom, len);
        n_sent++;
      end else if (pick < 85) begin
        if ($urandom_range(0, 99) < 88) sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
        else sym = SymW'($urandom_range(0, SymbolCount - 1));
        push_item(KIND_ENCODE, sym, $urandom, LenW'($urandom_range(0, 63)));
        n_sent++;
      end else if (pick < 93) begin
        push_item(KIND_FINISH, SymW'($urandom), $urandom, LenW'($urandom_range(0, 63)));
        n_sent++;
      end else begin
        push_item(KindUnused, SymW'($urandom), $urandom, LenW'($urandom_range(0, 63)));
      end
    end
    steady = 1'b0;
    push_item(KIND_FINISH, 8'h00, 32'h0, 6'd0);
    in_ch.valid <= 1'b0;

    // Drain, then give the block time to show any stray result
    while (book.owed_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (book.owed_bytes.size() != 0)
      book.report($sformatf("%0d results never arrived", book.owed_bytes.size()));

    $display("Ran %0d input transfers and checked %0d result transfers,",
             book.items_seen, book.results_seen);
    $display("including %0d unknown-symbol flags and %0d empty flushes; %0d mismatches.",
             book.unknown_seen, book.flushes_seen, book.errors);
    if (book.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("Timeout: results still outstanding");
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
